FILE: rtl/core/mdic_pkg.sv
// shared constants, codes and controller/datapath interface types of the index counter
package mdic_pkg;

    localparam int POS_W         = 48;
    localparam int IN_W          = 2 * POS_W;
    localparam int NUM_SIZE_REGS = 4;
    localparam int NUM_OUT_IDX   = 4;
    localparam int CFG_ADDR_W    = 3;
    localparam int NUM_DIMS_W    = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_DIMS  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_DIM0 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_DIM1 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_DIM2 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_DIM3 = 3'd4;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    typedef struct packed {
        logic load_start;
        logic div_start_split;
        logic split_store;
        logic emit_start;
        logic latch_rem;
        logic step0;
        logic div_start_outer;
        logic outer;
        logic mul;
        logic emit_done;
        logic emit_adv;
    } dp_cmd_t;

    typedef struct packed {
        logic split_last;
        logic div_done;
        logic pos_done;
        logic outer_cand;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/core/mdic_div.sv
// restoring divider of a linear position by a dimension extent, one quotient bit per cycle
module mdic_div #(
    parameter int SIZE_BITS = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mdic_pkg::POS_W-1:0]  dividend,
    input  logic [SIZE_BITS-1:0]        divisor,
    output logic                        done,
    output logic [mdic_pkg::POS_W-1:0]  quot,
    output logic [SIZE_BITS-1:0]        rem
);

    localparam int CNT_W = $clog2(mdic_pkg::POS_W);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [mdic_pkg::POS_W-1:0] q_reg;
    logic [SIZE_BITS-1:0]       r_reg;
    logic [SIZE_BITS-1:0]       d_reg;

    logic [SIZE_BITS:0]         trial;
    logic                       fits;
    logic [SIZE_BITS-1:0]       r_next;

    always_comb begin
        trial  = {r_reg, q_reg[mdic_pkg::POS_W-1]};
        fits   = trial >= {1'b0, d_reg};
        // remainder stays below the divisor, so it fits the extent width
        r_next = fits ? SIZE_BITS'(trial - {1'b0, d_reg}) : trial[SIZE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(mdic_pkg::POS_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= {q_reg[mdic_pkg::POS_W-2:0], fits};
            r_reg <= r_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

FILE: rtl/core/mdic_datapath.sv
// index counter datapath: config, indices, position, step logic and output register
module mdic_datapath #(
    parameter int MAX_DIMS  = 4,
    parameter int SIZE_BITS = 12,
    localparam int OUT_W    = ((6 * SIZE_BITS + mdic_pkg::POS_W + 2 + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mdic_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [SIZE_BITS-1:0]            cfg_wdata,
    input  logic [mdic_pkg::IN_W-1:0]       s_tdata,
    input  mdic_pkg::dp_cmd_t               cmd,
    output mdic_pkg::dp_status_t            status,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [OUT_W-1:0]                m_tdata
);

    localparam int POS_W = mdic_pkg::POS_W;
    localparam int ND_W  = $clog2(MAX_DIMS + 1);
    localparam int DI_W  = $clog2(MAX_DIMS);

    // configuration
    logic [mdic_pkg::NUM_DIMS_W-1:0] num_dims_reg;
    logic [SIZE_BITS-1:0]            size_reg [mdic_pkg::NUM_SIZE_REGS];

    // counter state
    logic [SIZE_BITS-1:0] dim_index_reg  [MAX_DIMS];
    logic [SIZE_BITS-1:0] dim_index_next [MAX_DIMS];
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     end_reg;
    logic [ND_W-1:0]      d_cnt_reg;

    // working registers
    logic [POS_W-1:0]       lin_reg;
    logic [POS_W-1:0]       rem_reg;
    logic [SIZE_BITS-1:0]   step0_reg;
    logic [SIZE_BITS-1:0]   step1_reg;
    logic                   outer_reg;
    logic [2*SIZE_BITS-1:0] prod_reg;

    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg;
    logic [OUT_W-1:0]       m_tdata_next;

    logic [ND_W-1:0]        nd;
    logic [SIZE_BITS-1:0]   ext [MAX_DIMS];
    logic [SIZE_BITS-1:0]   ext_split;
    logic [POS_W:0]         diff;
    logic                   pos_done;
    logic [SIZE_BITS-1:0]   avail0;
    logic [SIZE_BITS-1:0]   avail1;
    logic [SIZE_BITS-1:0]   step0_val;
    logic [SIZE_BITS-1:0]   step1_val;
    logic                   outer_cand;
    logic                   emit_any;
    logic [SIZE_BITS-1:0]   idx_out [mdic_pkg::NUM_OUT_IDX];

    logic                   div_start;
    logic [POS_W-1:0]       div_dividend;
    logic [SIZE_BITS-1:0]   div_divisor;
    logic                   div_done;
    logic [POS_W-1:0]       div_quot;
    logic [SIZE_BITS-1:0]   div_rem;

    // dimensions in use, clamped to 1..MAX_DIMS
    always_comb begin
        if (num_dims_reg == '0) begin
            nd = ND_W'(1);
        end else if (int'(num_dims_reg) > MAX_DIMS) begin
            nd = ND_W'(MAX_DIMS);
        end else begin
            nd = ND_W'(num_dims_reg);
        end
    end

    // effective extents: zero acts as one, dimensions past the size registers are one
    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (d < mdic_pkg::NUM_SIZE_REGS) begin
                ext[d] = (size_reg[d[1:0]] == '0) ? SIZE_BITS'(1) : size_reg[d[1:0]];
            end else begin
                ext[d] = SIZE_BITS'(1);
            end
        end
    end

    always_comb begin
        ext_split = SIZE_BITS'(1);
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (d_cnt_reg == ND_W'(d)) begin
                ext_split = ext[d];
            end
        end
    end

    always_comb begin
        diff     = {1'b0, end_reg} - {1'b0, pos_reg};
        pos_done = diff[POS_W] || (diff == '0);
    end

    // step sizes; a stale index counts as the last element of its row
    always_comb begin
        avail0 = (dim_index_reg[0] < ext[0]) ? SIZE_BITS'(ext[0] - dim_index_reg[0])
                                             : SIZE_BITS'(1);
        avail1 = (dim_index_reg[1] < ext[1]) ? SIZE_BITS'(ext[1] - dim_index_reg[1])
                                             : SIZE_BITS'(1);
        step0_val  = (rem_reg < POS_W'(avail0)) ? rem_reg[SIZE_BITS-1:0] : avail0;
        step1_val  = (div_quot < POS_W'(avail1)) ? div_quot[SIZE_BITS-1:0] : avail1;
        outer_cand = (step0_val == ext[0]) && (dim_index_reg[0] == '0)
                     && (nd >= ND_W'(2));
    end

    // add the step with carry across the dimensions in use
    always_comb begin
        logic [SIZE_BITS-1:0] carry;
        logic [SIZE_BITS:0]   sum;
        carry = outer_reg ? step1_reg : step0_reg;
        sum   = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            dim_index_next[d] = dim_index_reg[d];
            if ((d > 0 || !outer_reg) && ND_W'(d) < nd && carry != '0) begin
                sum = {1'b0, dim_index_reg[d]} + {1'b0, carry};
                if (sum >= {1'b0, ext[d]}) begin
                    dim_index_next[d] = '0;
                    carry             = SIZE_BITS'(1);
                end else begin
                    dim_index_next[d] = sum[SIZE_BITS-1:0];
                    carry             = '0;
                end
            end
        end
    end

    // reported indices, zero past the dimensions in use
    always_comb begin
        for (int k = 0; k < mdic_pkg::NUM_OUT_IDX; k++) begin
            idx_out[k] = '0;
        end
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (d < mdic_pkg::NUM_OUT_IDX && ND_W'(d) < nd) begin
                idx_out[d[1:0]] = dim_index_reg[d];
            end
        end
    end

    always_comb begin
        logic [SIZE_BITS-1:0] si;
        logic [SIZE_BITS-1:0] so;
        logic                 dn;
        logic                 bd;
        si = '0;
        so = '0;
        dn = 1'b0;
        bd = 1'b0;
        if (cmd.emit_adv) begin
            si = step0_reg;
            so = step1_reg;
        end else if (cmd.emit_done) begin
            dn = 1'b1;
        end else begin
            dn = pos_done;
            bd = lin_reg != '0;
        end
        m_tdata_next = OUT_W'({bd, dn, pos_reg, so, si,
                               idx_out[3], idx_out[2], idx_out[1], idx_out[0]});
    end

    assign emit_any = cmd.emit_start || cmd.emit_done || cmd.emit_adv;

    assign div_start    = cmd.div_start_split || cmd.div_start_outer;
    assign div_dividend = cmd.div_start_outer ? rem_reg : lin_reg;
    assign div_divisor  = cmd.div_start_outer ? ext[0] : ext_split;

    mdic_div #(
        .SIZE_BITS (SIZE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dims_reg <= mdic_pkg::NUM_DIMS_W'(1);
            for (int i = 0; i < mdic_pkg::NUM_SIZE_REGS; i++) begin
                size_reg[i] <= SIZE_BITS'(1);
            end
            for (int d = 0; d < MAX_DIMS; d++) begin
                dim_index_reg[d] <= '0;
            end
            pos_reg      <= '0;
            end_reg      <= '0;
            d_cnt_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    mdic_pkg::CFG_NUM_DIMS: begin
                        num_dims_reg <= cfg_wdata[mdic_pkg::NUM_DIMS_W-1:0];
                    end
                    mdic_pkg::CFG_SIZE_DIM0: size_reg[0] <= cfg_wdata;
                    mdic_pkg::CFG_SIZE_DIM1: size_reg[1] <= cfg_wdata;
                    mdic_pkg::CFG_SIZE_DIM2: size_reg[2] <= cfg_wdata;
                    mdic_pkg::CFG_SIZE_DIM3: size_reg[3] <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (cmd.load_start) begin
                pos_reg   <= s_tdata[POS_W-1:0];
                end_reg   <= s_tdata[2*POS_W-1:POS_W];
                d_cnt_reg <= '0;
                for (int d = 0; d < MAX_DIMS; d++) begin
                    dim_index_reg[d] <= '0;
                end
            end
            if (cmd.split_store) begin
                dim_index_reg[d_cnt_reg[DI_W-1:0]] <= div_rem;
                d_cnt_reg                          <= d_cnt_reg + 1'b1;
            end
            if (cmd.emit_adv) begin
                pos_reg <= pos_reg + POS_W'(prod_reg);
                for (int d = 0; d < MAX_DIMS; d++) begin
                    dim_index_reg[d] <= dim_index_next[d];
                end
            end
            if (emit_any) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_start) begin
            lin_reg <= s_tdata[POS_W-1:0];
        end else if (cmd.split_store) begin
            lin_reg <= div_quot;
        end
        if (cmd.latch_rem) begin
            rem_reg <= diff[POS_W-1:0];
        end
        if (cmd.step0) begin
            step0_reg <= step0_val;
            step1_reg <= SIZE_BITS'(1);
            outer_reg <= 1'b0;
        end else if (cmd.outer) begin
            step1_reg <= step1_val;
            outer_reg <= step1_val != SIZE_BITS'(1);
        end
        if (cmd.mul) begin
            prod_reg <= step0_reg * step1_reg;
        end
        if (emit_any) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_comb begin
        status.split_last = d_cnt_reg >= nd;
        status.div_done   = div_done;
        status.pos_done   = pos_done;
        status.outer_cand = outer_cand;
        status.out_free   = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/core/mdic_ctrl.sv
// index counter sequencer: start split over dimensions and advance step sequence
module mdic_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_action,
    input  mdic_pkg::dp_status_t status,
    output mdic_pkg::dp_cmd_t    cmd,
    output logic                 s_tready
);

    typedef enum logic [10:0] {
        ST_IDLE       = 11'b000_0000_0001,
        ST_SPLIT_GO   = 11'b000_0000_0010,
        ST_SPLIT_WAIT = 11'b000_0000_0100,
        ST_START_EMIT = 11'b000_0000_1000,
        ST_ADV_EVAL   = 11'b000_0001_0000,
        ST_DONE_EMIT  = 11'b000_0010_0000,
        ST_ADV_STEP0  = 11'b000_0100_0000,
        ST_OUTER_WAIT = 11'b000_1000_0000,
        ST_ADV_MUL    = 11'b001_0000_0000,
        ST_ADV_EMIT   = 11'b010_0000_0000,
        ST_ADV_OUTER  = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_action == mdic_pkg::ACT_START) begin
                        cmd.load_start = 1'b1;
                        state_next     = ST_SPLIT_GO;
                    end else begin
                        state_next = ST_ADV_EVAL;
                    end
                end
            end
            ST_SPLIT_GO: begin
                if (status.split_last) begin
                    state_next = ST_START_EMIT;
                end else begin
                    cmd.div_start_split = 1'b1;
                    state_next          = ST_SPLIT_WAIT;
                end
            end
            ST_SPLIT_WAIT: begin
                if (status.div_done) begin
                    cmd.split_store = 1'b1;
                    state_next      = ST_SPLIT_GO;
                end
            end
            ST_START_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_ADV_EVAL: begin
                if (status.pos_done) begin
                    state_next = ST_DONE_EMIT;
                end else begin
                    cmd.latch_rem = 1'b1;
                    state_next    = ST_ADV_STEP0;
                end
            end
            ST_DONE_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_ADV_STEP0: begin
                cmd.step0 = 1'b1;
                // a whole row fits: find how many rows the remainder covers
                if (status.outer_cand) begin
                    cmd.div_start_outer = 1'b1;
                    state_next          = ST_OUTER_WAIT;
                end else begin
                    state_next = ST_ADV_MUL;
                end
            end
            ST_OUTER_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_ADV_OUTER;
                end
            end
            ST_ADV_OUTER: begin
                cmd.outer  = 1'b1;
                state_next = ST_ADV_MUL;
            end
            ST_ADV_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ADV_EMIT;
            end
            ST_ADV_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_adv = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;

endmodule

FILE: rtl/core/multidim_index_counter.sv
// top level of the multidimensional index counter
//
// A beat on the s_ channel is a start (s_tuser = 0) carrying a linear range
// [range_begin, range_end), or an advance (s_tuser = 1). Every accepted beat
// yields exactly one result beat on the m_ channel with the indices, the step
// and the linear offset. Shape registers are to be written through cfg_we/cfg_addr/
// cfg_wdata only while the counter is idle; the block itself does not enforce this.
// Beat time is set by the shared bit-serial divider: a start runs one division
// per dimension in use, an advance over a row run one division of the remainder
// by extent 0, and an inner-only advance or an advance when done runs none.
// One beat is worked on at a time; a result waits in the output register, so
// the next beat is taken while the receiver stalls, and only a second finished
// result waits for m_tready. After reset the shape is one dimension of extent
// one, all indices and positions are zero and no result is pending.
module multidim_index_counter #(
    parameter int MAX_DIMS  = 4,
    parameter int SIZE_BITS = 12,
    localparam int OUT_W    = ((6 * SIZE_BITS + mdic_pkg::POS_W + 2 + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mdic_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [SIZE_BITS-1:0]            cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // range_begin, range_end
    input  logic [mdic_pkg::IN_W-1:0]       s_tdata,
    // action
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // index0, index1, index2, index3, step_inner, step_outer, offset,
    // done_res, bad_start, zero fill
    output logic [OUT_W-1:0]                m_tdata
);

    mdic_pkg::dp_cmd_t    cmd;
    mdic_pkg::dp_status_t status;

    mdic_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_action (s_tuser[0]),
        .status   (status),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    mdic_datapath #(
        .MAX_DIMS  (MAX_DIMS),
        .SIZE_BITS (SIZE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: tb/tb.sv
// self-checking testbench for the multidimensional index counter
module tb;

    localparam int POS_W       = mdic_pkg::POS_W;
    localparam int IN_W        = mdic_pkg::IN_W;
    localparam int CFG_ADDR_W  = mdic_pkg::CFG_ADDR_W;
    localparam int SB          = 12;
    localparam int DIMS        = 4;
    localparam int OUT_W       = 128;
    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RAND_BEATS  = 1950;
    localparam int PHASE_BEATS = 50;
    localparam int RUN_CAP     = 40;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [CFG_ADDR_W-1:0] SIZE_ADDR [DIMS] =
        '{mdic_pkg::CFG_SIZE_DIM0, mdic_pkg::CFG_SIZE_DIM1,
          mdic_pkg::CFG_SIZE_DIM2, mdic_pkg::CFG_SIZE_DIM3};

    // same layout as m_tdata from bit 0 up: idx0 is the lowest field
    typedef struct packed {
        logic             bad;
        logic             done;
        logic [POS_W-1:0] offset;
        logic [SB-1:0]    step_outer;
        logic [SB-1:0]    step_inner;
        logic [SB-1:0]    idx3, idx2, idx1, idx0;
    } count_res_t;

    typedef enum logic {ROW_SHAPE, ROW_BEAT} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [2:0]         nd;
        logic [0:3][SB-1:0] sz;
        logic               act;
        logic [POS_W-1:0]   rbeg, rend;
        logic               known;
        count_res_t         res;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [30] = '{
        // right after reset: advance reports done
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b1,
          '{1'b0, 1'b1, 48'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_START, 48'd0, 48'd0, 1'b1,
          '{1'b0, 1'b1, 48'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}},
        // begin beyond a 1x1 shape
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_START, 48'd5, 48'd10, 1'b1,
          '{1'b1, 1'b0, 48'd5, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_SHAPE, 3'd4, '{12'd4095, 12'd4095, 12'd4095, 12'd4095},
          1'b0, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_START, POS_MAX, POS_MAX, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_START, 48'd0, POS_MAX, 1'b1,
          '{1'b0, 1'b0, 48'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}},
        // full row run over the widest plane
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b1,
          '{1'b0, 1'b0, 48'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0}},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b0, '0},
        // zero dims and zero extents act as one
        '{ROW_SHAPE, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0},
          1'b0, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_START, 48'd3, 48'd7, 1'b1,
          '{1'b1, 1'b0, 48'd3, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b0, '0},
        // dims above the maximum clamp to four
        '{ROW_SHAPE, 3'd7, '{12'd3, 12'd2, 12'd2, 12'd2},
          1'b0, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_START, 48'd0, 48'd20, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_START, 48'd23, 48'd24, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_START, 48'd24, 48'd30, 1'b0, '0},
        // end below begin
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_START, 48'd10, 48'd2, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_SHAPE, 3'd2, '{12'd5, 12'd4095, 12'd1, 12'd1},
          1'b0, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_START, 48'd4, 48'd100, 1'b0, '0},
        // shrink extent 0 under a live index
        '{ROW_SHAPE, 3'd2, '{12'd3, 12'd4095, 12'd1, 12'd1},
          1'b0, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_BEAT, 3'd0, '0, mdic_pkg::ACT_ADVANCE, 48'd0, 48'd0, 1'b0, '0}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [SB-1:0]         cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;

    // shadow of the shape registers and the counter state
    logic [2:0]       nd_cfg = 3'd1;
    logic [SB-1:0]    size_cfg [DIMS] = '{default: 12'd1};
    logic [SB-1:0]    idx_st [DIMS] = '{default: '0};
    logic [POS_W-1:0] pos_st = '0;
    logic [POS_W-1:0] end_st = '0;

    count_res_t pending_q [$];
    int         err_cnt   = 0;
    int         send_idle = 0;
    int         recv_idle = 0;
    int         cycles    = 0;

    multidim_index_counter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic int dims_used();
        int n;
        n = int'(nd_cfg);
        if (n < 1) n = 1;
        if (n > DIMS) n = DIMS;
        return n;
    endfunction

    function automatic longint unsigned extent_of(int d);
        return (size_cfg[d] == '0) ? 64'd1 : 64'(size_cfg[d]);
    endfunction

    function automatic count_res_t snapshot();
        count_res_t r;
        int nd;
        nd = dims_used();
        r = '0;
        r.idx0   = idx_st[0];
        r.idx1   = (nd > 1) ? idx_st[1] : '0;
        r.idx2   = (nd > 2) ? idx_st[2] : '0;
        r.idx3   = (nd > 3) ? idx_st[3] : '0;
        r.offset = pos_st;
        return r;
    endfunction

    // one accepted beat: returns the report and moves the shadow state on
    function automatic count_res_t count_step(logic act, logic [POS_W-1:0] rbeg, rend);
        count_res_t r;
        longint unsigned lin, rem, s0, s1, v0, v1, avail, step0, step1, carry, v;
        int nd, i;
        logic outer;
        nd = dims_used();
        if (act == mdic_pkg::ACT_START) begin
            lin = 64'(rbeg);
            for (i = 0; i < DIMS; i++) idx_st[i] = '0;
            for (i = 0; i < nd; i++) begin
                idx_st[i] = SB'(lin % extent_of(i));
                lin = lin / extent_of(i);
            end
            pos_st = rbeg;
            end_st = rend;
            r = snapshot();
            r.bad  = (lin != 0);
            r.done = (pos_st >= end_st);
        end else if (pos_st >= end_st) begin
            r = snapshot();
            r.done = 1'b1;
        end else begin
            r = snapshot();
            rem   = 64'(end_st - pos_st);
            s0    = extent_of(0);
            v0    = 64'(idx_st[0]);
            avail = (v0 < s0) ? s0 - v0 : 64'd1;
            step0 = (avail < rem) ? avail : rem;
            step1 = 64'd1;
            outer = 1'b0;
            if (step0 == s0 && v0 == 0 && nd >= 2) begin
                s1    = extent_of(1);
                v1    = 64'(idx_st[1]);
                avail = (v1 < s1) ? s1 - v1 : 64'd1;
                step1 = (avail < rem / s0) ? avail : rem / s0;
                outer = (step1 != 1);
            end
            r.step_inner = SB'(step0);
            r.step_outer = SB'(step1);
            pos_st = POS_W'(pos_st + step0 * step1);
            // carry ripples out from dim 0, or from dim 1 after a row run
            carry = outer ? step1 : step0;
            i     = outer ? 1 : 0;
            while (i < nd && carry > 0) begin
                v = 64'(idx_st[i]) + carry;
                if (v >= extent_of(i)) begin
                    v     = 64'd0;
                    carry = 64'd1;
                end else begin
                    carry = 64'd0;
                end
                idx_st[i] = SB'(v);
                i++;
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned want, got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic send_beat(input logic act, input logic [POS_W-1:0] rbeg, rend,
                             input logic known, input count_res_t fixed);
        count_res_t exp_res;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {rend, rbeg};
        do @(posedge aclk); while (!s_tready);
        exp_res = count_step(act, rbeg, rend);
        pending_q.insert(pending_q.size(), known ? fixed : exp_res);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_shape(input logic [2:0] nd, input logic [0:3][SB-1:0] sz);
        cfg_we    <= 1'b1;
        cfg_addr  <= mdic_pkg::CFG_NUM_DIMS;
        cfg_wdata <= SB'(nd);
        @(posedge aclk);
        nd_cfg = nd;
        for (int d = 0; d < DIMS; d++) begin
            cfg_addr  <= SIZE_ADDR[d];
            cfg_wdata <= sz[d];
            @(posedge aclk);
            size_cfg[d] = sz[d];
        end
        cfg_we <= 1'b0;
    endtask

    // result side: random back-pressure and in-order compare
    always @(posedge aclk) begin
        count_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = count_res_t'(m_tdata[$bits(count_res_t)-1:0]);
            if (pending_q.size() == 0) begin
                $error("result beat with nothing expected");
                err_cnt++;
            end else begin
                want = pending_q.pop_front();
                check_field("index0", 64'(want.idx0), 64'(got.idx0));
                check_field("index1", 64'(want.idx1), 64'(got.idx1));
                check_field("index2", 64'(want.idx2), 64'(got.idx2));
                check_field("index3", 64'(want.idx3), 64'(got.idx3));
                check_field("step_inner", 64'(want.step_inner), 64'(got.step_inner));
                check_field("step_outer", 64'(want.step_outer), 64'(got.step_outer));
                check_field("offset", 64'(want.offset), 64'(got.offset));
                check_field("done_res", 64'(want.done), 64'(got.done));
                check_field("bad_start", 64'(want.bad), 64'(got.bad));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("multidim_index_counter test failed");
            $finish;
        end
    end

    initial begin
        logic [2:0]         nd;
        logic [0:3][SB-1:0] sz;
        logic               act;
        logic [POS_W-1:0]   rbeg, rend;
        longint unsigned    total, span, lim;
        int                 sent, stop, phase, n;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle = 27;
        recv_idle = 78;
        foreach (DIR_TAB[k]) begin
            if (DIR_TAB[k].kind == ROW_SHAPE) begin
                settle();
                write_shape(DIR_TAB[k].nd, DIR_TAB[k].sz);
            end else begin
                send_beat(DIR_TAB[k].act, DIR_TAB[k].rbeg, DIR_TAB[k].rend,
                          DIR_TAB[k].known, DIR_TAB[k].res);
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < RAND_BEATS) begin
            if (sent < RAND_BEATS / 3) begin
                send_idle = 27;
                recv_idle = 78;
            end else if (sent < 2 * RAND_BEATS / 3) begin
                send_idle = 78;
                recv_idle = 27;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            settle();
            case (phase % 6)
                0: begin
                    nd = 3'd4;
                    sz = '{12'd4095, 12'd4095, 12'd4095, 12'd4095};
                end
                1: begin
                    nd = 3'd1;
                    sz = '{12'd1, 12'd1, 12'd1, 12'd1};
                end
                default: begin
                    nd = ($urandom_range(3) == 0) ? 3'($urandom_range(7))
                                                  : 3'($urandom_range(1, 4));
                    for (int d = 0; d < DIMS; d++) begin
                        case ($urandom_range(9))
                            0:       sz[d] = '0;
                            1:       sz[d] = SB'($urandom_range(1, 4095));
                            2:       sz[d] = '1;
                            default: sz[d] = SB'($urandom_range(1, 12));
                        endcase
                    end
                end
            endcase
            write_shape(nd, sz);
            phase++;

            // carry on with the old range under the new shape (stale indices)
            n = $urandom_range(0, 3);
            repeat (n) send_beat(mdic_pkg::ACT_ADVANCE, POS_W'({$urandom, $urandom}),
                                 POS_W'({$urandom, $urandom}), 1'b0, '0);
            sent += n;

            stop = sent + PHASE_BEATS;
            while (sent < stop) begin
                if ($urandom_range(9) < 8) begin
                    total = 1;
                    for (int d = 0; d < dims_used(); d++) total *= extent_of(d);
                    rbeg = POS_W'({$urandom, $urandom} % total);
                    case ($urandom_range(2))
                        0:       span = 64'(1 + $urandom_range(0, 2 * 32'(size_cfg[0])));
                        1:       span = 64'($urandom_range(1, 200));
                        default: span = total;
                    endcase
                    lim  = (span < total - rbeg) ? span : total - rbeg;
                    rend = POS_W'(rbeg + 1 + {$urandom, $urandom} % lim);
                    send_beat(mdic_pkg::ACT_START, rbeg, rend, 1'b0, '0);
                    sent++;
                    n = 0;
                    while (pos_st < end_st && n < RUN_CAP) begin
                        send_beat(mdic_pkg::ACT_ADVANCE, POS_W'({$urandom, $urandom}),
                                  POS_W'({$urandom, $urandom}), 1'b0, '0);
                        n++;
                    end
                    if (pos_st >= end_st && $urandom_range(1) == 1) begin
                        send_beat(mdic_pkg::ACT_ADVANCE, '0, '0, 1'b0, '0);
                        n++;
                    end
                    sent += n;
                end else begin
                    act  = 1'($urandom_range(1));
                    rbeg = $urandom_range(1) ? POS_W'({$urandom, $urandom})
                                             : POS_W'($urandom_range(0, 300));
                    rend = $urandom_range(1) ? POS_W'({$urandom, $urandom})
                                             : POS_W'($urandom_range(0, 300));
                    send_beat(act, rbeg, rend, 1'b0, '0);
                    sent++;
                end
            end
        end

        settle();
        repeat (60) @(posedge aclk);
        if (err_cnt == 0 && pending_q.size() == 0) begin
            $display("multidim_index_counter test passed");
        end else begin
            $display("multidim_index_counter test failed");
        end
        $finish;
    end

endmodule
